// ===== hdl/bary_pkg.sv =====
// Shared widths, types and the pipeline tag for the barycentric weight pipeline.
package bary_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW        = 32;
    localparam int NIN       = 12;
    localparam int NLANE     = 3;
    localparam int DW        = CW + 1;
    localparam int PW        = 2 * DW;
    localparam int MW        = PW;
    localparam int HW        = MW / 2;
    localparam int SW        = 2 * MW;
    localparam int WT_W      = FRAC_BITS + 2;
    localparam int QB        = 2 * WT_W;
    localparam int LOWB      = QB - 2 * FRAC_BITS;
    localparam int RSW       = WT_W + 3;
    localparam int OUT_BITS  = NLANE * WT_W;
    localparam int S_TDATA_W = NIN * CW;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef logic signed [DW-1:0] diff_t;
    typedef logic [SW-1:0]        area_t;
    typedef logic [QB-1:0]        quo_t;
    typedef logic [WT_W-1:0]      weight_t;

    typedef struct packed {
        logic             valid;
        logic             degen;
        logic [NLANE-1:0] sat;
    } bary_tag_t;

endpackage

// ===== hdl/triangle_barycentric_weights.sv =====
// Top level: barycentric weights by area ratio, fully pipelined.
//
//  channel  | direction | tdata (low bit up)                               | tuser
//  s_       | request in| point_x/y/z, vertex_a x/y/z, b x/y/z, c x/y/z     | -
//  m_       | result out| weight_a, weight_b, weight_c, 2 zero pad bits    | degenerate
//
// One request per cycle unless the output holds; a result reaches m_tvalid through
// 62 registers: difference stage, five cross/square stages, a 37-stage divider (a
// setup stage, then one quotient bit per stage), an 18-stage square root and the
// output register. Reset clears only valid and tag bits and holds s_tready low.
// When a result waits at the output, the whole pipeline holds and s_tready drops
// until m_tready returns.
module triangle_barycentric_weights (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // point_x, point_y, point_z, vertex_a_x .. vertex_c_z, 32 bits each
    input  logic [bary_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // weight_a, weight_b, weight_c, zero pad
    output logic [bary_pkg::M_TDATA_W-1:0]    m_tdata,
    // degenerate
    output logic                              m_tuser
);
    import bary_pkg::*;

    logic       adv;
    logic       v0_reg;
    diff_t      pa_reg [3];
    diff_t      pb_reg [3];
    diff_t      pc_reg [3];
    diff_t      ab_reg [3];
    diff_t      ac_reg [3];
    diff_t      pa_next [3];
    diff_t      pb_next [3];
    diff_t      pc_next [3];
    diff_t      ab_next [3];
    diff_t      ac_next [3];
    diff_t      pt [3];
    diff_t      va [3];
    diff_t      vb [3];
    diff_t      vc [3];
    logic [3:0] xv;
    area_t      whole;
    area_t      subs [NLANE];
    bary_tag_t  dv_tag;
    quo_t       dv_quo [NLANE];
    bary_tag_t  sq_tag;
    weight_t    sq_root [NLANE];
    weight_t    wt_reg [NLANE];
    weight_t    wt_next [NLANE];
    logic       degen_reg;
    logic       mvalid_reg;

    assign adv      = !mvalid_reg || m_tready;
    assign s_tready = adv && aresetn;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pt[i] = DW'($signed(s_tdata[i*CW +: CW]));
            va[i] = DW'($signed(s_tdata[(3+i)*CW +: CW]));
            vb[i] = DW'($signed(s_tdata[(6+i)*CW +: CW]));
            vc[i] = DW'($signed(s_tdata[(9+i)*CW +: CW]));
            pa_next[i] = va[i] - pt[i];
            pb_next[i] = vb[i] - pt[i];
            pc_next[i] = vc[i] - pt[i];
            ab_next[i] = va[i] - vb[i];
            ac_next[i] = va[i] - vc[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            pc_reg <= pc_next;
            ab_reg <= ab_next;
            ac_reg <= ac_next;
        end
    end

    bary_cross u_whole (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(v0_reg),
        .u(ab_reg), .v(ac_reg), .out_valid(xv[0]), .sum_sq(whole)
    );
    bary_cross u_sub_a (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(v0_reg),
        .u(pb_reg), .v(pc_reg), .out_valid(xv[1]), .sum_sq(subs[0])
    );
    bary_cross u_sub_b (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(v0_reg),
        .u(pc_reg), .v(pa_reg), .out_valid(xv[2]), .sum_sq(subs[1])
    );
    bary_cross u_sub_c (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(v0_reg),
        .u(pa_reg), .v(pb_reg), .out_valid(xv[3]), .sum_sq(subs[2])
    );

    bary_div u_div (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(xv[0]),
        .den_in(whole), .num_in(subs), .tag_out(dv_tag), .quo_out(dv_quo)
    );

    bary_sqrt u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .tag_in(dv_tag),
        .rad_in(dv_quo), .tag_out(sq_tag), .root_out(sq_root)
    );

    always_comb begin
        for (int l = 0; l < NLANE; l++) begin
            if (sq_tag.degen) begin
                wt_next[l] = '0;
            end else if (sq_tag.sat[l]) begin
                wt_next[l] = '1;
            end else begin
                wt_next[l] = sq_root[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else if (adv) begin
            mvalid_reg <= sq_tag.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            wt_reg    <= wt_next;
            degen_reg <= sq_tag.degen;
        end
    end

    assign m_tvalid = mvalid_reg;
    assign m_tuser  = degen_reg;
    assign m_tdata  = M_TDATA_W'({wt_reg[2], wt_reg[1], wt_reg[0]});

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[OUT_BITS-1:0] == '0)
        else $error("degenerate result with nonzero weights");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_sat_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && sq_tag.valid && !sq_tag.degen && sq_tag.sat[0]
        |=> m_tvalid && m_tdata[WT_W-1:0] == '1)
        else $error("saturated lane not all ones");

    a_lanes_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        xv[0] == xv[1] && xv[1] == xv[2] && xv[2] == xv[3])
        else $error("cross product lanes out of step");

endmodule

// ===== hdl/bary_cross.sv =====
// Squared cross-product magnitude of two difference vectors, five register stages.
module bary_cross (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  bary_pkg::diff_t       u [3],
    input  bary_pkg::diff_t       v [3],
    output logic                  out_valid,
    output bary_pkg::area_t       sum_sq
);
    import bary_pkg::*;

    logic signed [PW-1:0] prod_reg [6];
    logic signed [PW-1:0] prod_next [6];
    logic [MW-1:0]        mag_reg [3];
    logic [MW-1:0]        mag_next [3];
    logic [MW-1:0]        hh_reg [3];
    logic [MW-1:0]        hl_reg [3];
    logic [MW-1:0]        ll_reg [3];
    logic [MW-1:0]        hh_next [3];
    logic [MW-1:0]        hl_next [3];
    logic [MW-1:0]        ll_next [3];
    area_t                sq_reg [3];
    area_t                sq_next [3];
    area_t                sum_reg;
    area_t                sum_next;
    logic [4:0]           vld_reg;
    logic [4:0]           vld_next;
    logic signed [PW:0]   cd;
    logic [HW-1:0]        mh;
    logic [HW-1:0]        ml;

    always_comb begin
        prod_next[0] = u[1] * v[2];
        prod_next[1] = u[2] * v[1];
        prod_next[2] = u[2] * v[0];
        prod_next[3] = u[0] * v[2];
        prod_next[4] = u[0] * v[1];
        prod_next[5] = u[1] * v[0];
        cd = '0;
        mh = '0;
        ml = '0;
        for (int k = 0; k < 3; k++) begin
            cd = {prod_reg[2*k][PW-1], prod_reg[2*k]}
               - {prod_reg[2*k+1][PW-1], prod_reg[2*k+1]};
            mag_next[k] = cd[PW] ? MW'(-cd) : MW'(cd);
            mh = mag_reg[k][MW-1:HW];
            ml = mag_reg[k][HW-1:0];
            hh_next[k] = mh * mh;
            hl_next[k] = mh * ml;
            ll_next[k] = ml * ml;
            sq_next[k] = {hh_reg[k], {MW{1'b0}}}
                       + (SW'(hl_reg[k]) << (HW + 1))
                       + SW'(ll_reg[k]);
        end
        sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
        vld_next = {vld_reg[3:0], in_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
            mag_reg  <= mag_next;
            hh_reg   <= hh_next;
            hl_reg   <= hl_next;
            ll_reg   <= ll_next;
            sq_reg   <= sq_next;
            sum_reg  <= sum_next;
        end
    end

    assign out_valid = vld_reg[4];
    assign sum_sq    = sum_reg;

endmodule

// ===== hdl/bary_div.sv =====
// Pipelined restoring divider, one quotient bit per stage after the first, three lanes sharing a divisor.
module bary_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  logic                  in_valid,
    input  bary_pkg::area_t       den_in,
    input  bary_pkg::area_t       num_in [bary_pkg::NLANE],
    output bary_pkg::bary_tag_t   tag_out,
    output bary_pkg::quo_t        quo_out [bary_pkg::NLANE]
);
    import bary_pkg::*;

    bary_tag_t     tag_reg [QB+1];
    area_t         den_reg [QB+1];
    area_t         rem_reg [QB+1][NLANE];
    quo_t          low_reg [QB+1][NLANE];
    quo_t          quo_reg [QB+1][NLANE];
    bary_tag_t     tag_next [QB+1];
    area_t         rem_next [QB+1][NLANE];
    quo_t          low_next [QB+1][NLANE];
    quo_t          quo_next [QB+1][NLANE];
    logic [SW:0]   trial;
    logic          ge;
    area_t         head;

    always_comb begin
        tag_next[0].valid = in_valid;
        tag_next[0].degen = (den_in == '0);
        trial = '0;
        ge    = 1'b0;
        head  = '0;
        for (int l = 0; l < NLANE; l++) begin
            head = num_in[l] >> LOWB;
            tag_next[0].sat[l] = (head >= den_in);
            rem_next[0][l] = head;
            low_next[0][l] = {num_in[l][LOWB-1:0], {(QB-LOWB){1'b0}}};
            quo_next[0][l] = '0;
        end
        for (int j = 1; j <= QB; j++) begin
            tag_next[j] = tag_reg[j-1];
            for (int l = 0; l < NLANE; l++) begin
                trial = {rem_reg[j-1][l], low_reg[j-1][l][QB-1]};
                ge = (trial >= {1'b0, den_reg[j-1]});
                rem_next[j][l] = ge ? SW'(trial - {1'b0, den_reg[j-1]}) : trial[SW-1:0];
                low_next[j][l] = low_reg[j-1][l] << 1;
                quo_next[j][l] = {quo_reg[j-1][l][QB-2:0], ge};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j <= QB; j++) begin
                tag_reg[j] <= '0;
            end
        end else if (adv) begin
            tag_reg <= tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            den_reg[0] <= den_in;
            for (int j = 1; j <= QB; j++) begin
                den_reg[j] <= den_reg[j-1];
            end
            rem_reg <= rem_next;
            low_reg <= low_next;
            quo_reg <= quo_next;
        end
    end

    assign tag_out = tag_reg[QB];
    assign quo_out = quo_reg[QB];

endmodule

// ===== hdl/bary_sqrt.sv =====
// Pipelined digit-by-digit integer square root, one root bit per stage, three lanes.
module bary_sqrt (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  adv,
    input  bary_pkg::bary_tag_t   tag_in,
    input  bary_pkg::quo_t        rad_in [bary_pkg::NLANE],
    output bary_pkg::bary_tag_t   tag_out,
    output bary_pkg::weight_t     root_out [bary_pkg::NLANE]
);
    import bary_pkg::*;

    bary_tag_t        tag_reg [WT_W];
    logic [RSW-1:0]   rem_reg [WT_W][NLANE];
    weight_t          root_reg [WT_W][NLANE];
    quo_t             rad_reg [WT_W][NLANE];
    bary_tag_t        tag_next [WT_W];
    logic [RSW-1:0]   rem_next [WT_W][NLANE];
    weight_t          root_next [WT_W][NLANE];
    quo_t             rad_next [WT_W][NLANE];
    logic [RSW-1:0]   src_rem;
    weight_t          src_root;
    quo_t             src_rad;
    logic [RSW-1:0]   ext;
    logic [RSW-1:0]   trial;
    logic             ge;

    always_comb begin
        src_rem  = '0;
        src_root = '0;
        src_rad  = '0;
        ext      = '0;
        trial    = '0;
        ge       = 1'b0;
        for (int i = 0; i < WT_W; i++) begin
            tag_next[i] = (i == 0) ? tag_in : tag_reg[(i == 0) ? 0 : i-1];
            for (int l = 0; l < NLANE; l++) begin
                if (i == 0) begin
                    src_rem  = '0;
                    src_root = '0;
                    src_rad  = rad_in[l];
                end else begin
                    src_rem  = rem_reg[i-1][l];
                    src_root = root_reg[i-1][l];
                    src_rad  = rad_reg[i-1][l];
                end
                ext   = {src_rem[RSW-3:0], src_rad[QB-1:QB-2]};
                trial = RSW'({src_root, 2'b01});
                ge    = (ext >= trial);
                rem_next[i][l]  = ge ? ext - trial : ext;
                root_next[i][l] = {src_root[WT_W-2:0], ge};
                rad_next[i][l]  = src_rad << 2;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WT_W; i++) begin
                tag_reg[i] <= '0;
            end
        end else if (adv) begin
            tag_reg <= tag_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            rad_reg  <= rad_next;
        end
    end

    assign tag_out  = tag_reg[WT_W-1];
    assign root_out = root_reg[WT_W-1];

endmodule

// ===== tb/triangle_barycentric_weights_tb.sv =====
// Testbench for the barycentric weight pipeline: directed table, random requests, exact predictor.
module triangle_barycentric_weights_tb;
    import bary_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int N_RANDOM    = 1650;
    localparam logic [WT_W-1:0] WT_SAT = {WT_W{1'b1}};
    localparam logic [WT_W-1:0] WT_ONE = WT_W'(1) << FRAC_BITS;

    typedef struct {
        logic [WT_W-1:0] wa;
        logic [WT_W-1:0] wb;
        logic [WT_W-1:0] wc;
        logic            degen;
    } weights_t;

    typedef struct {
        logic [S_TDATA_W-1:0] data;
        bit                   typed;
        weights_t             want;
    } request_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    request_t requests[$];
    request_t cur_req;
    weights_t pending_weights[$];
    int       err_count = 0;
    int       cycle_count = 0;
    bit       no_idle = 1'b0;

    triangle_barycentric_weights u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [255:0] cross_sq(input logic signed [127:0] ux, uy, uz,
                                              input logic signed [127:0] vx, vy, vz);
        logic signed [127:0] cx, cy, cz;
        logic [127:0]        ax, ay, az;
        logic [255:0]        mx, my, mz;
        cx = uy * vz - uz * vy;
        cy = uz * vx - ux * vz;
        cz = ux * vy - uy * vx;
        ax = cx[127] ? -cx : cx;
        ay = cy[127] ? -cy : cy;
        az = cz[127] ? -cz : cz;
        mx = {128'b0, ax};
        my = {128'b0, ay};
        mz = {128'b0, az};
        return mx * mx + my * my + mz * mz;
    endfunction

    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] r, bits;
        r = 0;
        bits = 64'd1 << 62;
        while (bits > x) bits = bits >> 2;
        while (bits != 0) begin
            if (x >= r + bits) begin
                x = x - (r + bits);
                r = (r >> 1) + bits;
            end else begin
                r = r >> 1;
            end
            bits = bits >> 2;
        end
        return r;
    endfunction

    function automatic logic [WT_W-1:0] area_ratio(input logic [255:0] s, w);
        logic [255:0] q;
        logic [63:0]  root;
        q = (s << (2 * FRAC_BITS)) / w;
        if (q >= (256'd1 << QB)) return WT_SAT;
        root = isqrt(q[63:0]);
        return root[WT_W-1:0];
    endfunction

    function automatic logic signed [127:0] coord(input logic [S_TDATA_W-1:0] d, input int i);
        logic signed [31:0] v;
        v = d[32*i +: 32];
        return v;
    endfunction

    function automatic weights_t predict_weights(input logic [S_TDATA_W-1:0] d);
        logic signed [127:0] pa[3], pb[3], pc[3], ab[3], ac[3];
        logic [255:0]        whole;
        weights_t            r;
        for (int i = 0; i < 3; i++) begin
            pa[i] = coord(d, 3 + i) - coord(d, i);
            pb[i] = coord(d, 6 + i) - coord(d, i);
            pc[i] = coord(d, 9 + i) - coord(d, i);
            ab[i] = coord(d, 3 + i) - coord(d, 6 + i);
            ac[i] = coord(d, 3 + i) - coord(d, 9 + i);
        end
        whole = cross_sq(ab[0], ab[1], ab[2], ac[0], ac[1], ac[2]);
        r = '{default: '0};
        if (whole == 0) begin
            r.degen = 1'b1;
            return r;
        end
        r.wa = area_ratio(cross_sq(pb[0], pb[1], pb[2], pc[0], pc[1], pc[2]), whole);
        r.wb = area_ratio(cross_sq(pc[0], pc[1], pc[2], pa[0], pa[1], pa[2]), whole);
        r.wc = area_ratio(cross_sq(pa[0], pa[1], pa[2], pb[0], pb[1], pb[2]), whole);
        return r;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_tri(input int p[3], a[3], b[3], c[3]);
        logic [S_TDATA_W-1:0] d;
        for (int i = 0; i < 3; i++) begin
            d[32*i +: 32]       = p[i];
            d[32*(3+i) +: 32]   = a[i];
            d[32*(6+i) +: 32]   = b[i];
            d[32*(9+i) +: 32]   = c[i];
        end
        return d;
    endfunction

    task automatic add_row(input int p[3], a[3], b[3], c[3], input bit typed,
                           input logic [WT_W-1:0] wa, wb, wc, input logic degen);
        request_t rq;
        rq.data  = pack_tri(p, a, b, c);
        rq.typed = typed;
        rq.want  = '{wa, wb, wc, degen};
        requests.push_back(rq);
    endtask

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int small_coord();
        return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endfunction

    task automatic add_random();
        int p[3], a[3], b[3], c[3];
        int kind, t, u, k;
        kind = $urandom_range(0, 99);
        for (int i = 0; i < 3; i++) begin
            a[i] = small_coord();
            b[i] = small_coord();
            c[i] = small_coord();
            p[i] = small_coord();
        end
        if (kind < 20) begin
            for (int i = 0; i < 3; i++) begin
                a[i] = $urandom; b[i] = $urandom; c[i] = $urandom; p[i] = $urandom;
            end
        end else if (kind < 70) begin
            t = $urandom_range(0, 256);
            u = $urandom_range(0, 256 - t);
            for (int i = 0; i < 3; i++) begin
                p[i] = a[i] + ((b[i] - a[i]) / 256) * t + ((c[i] - a[i]) / 256) * u;
                if (kind >= 60) p[i] = p[i] + $urandom_range(0, 2000) - 1000;
            end
        end else if (kind < 80) begin
            k = $urandom_range(0, 3) - 1;
            for (int i = 0; i < 3; i++) c[i] = a[i] + k * (b[i] - a[i]);
        end else if (kind < 85) begin
            for (int i = 0; i < 3; i++) b[i] = a[i];
        end
        add_row(p, a, b, c, 1'b0, '0, '0, '0, 1'b0);
    endtask

    task automatic report_mismatch(input string what, input logic [WT_W-1:0] got, want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
        err_count++;
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("triangle_barycentric_weights_tb: done, errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            pending_weights.push_back(cur_req.typed ? cur_req.want : predict_weights(cur_req.data));
    end

    always @(posedge aclk) begin
        weights_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_weights.size() == 0) begin
                $display("unexpected result at cycle %0d", cycle_count);
                err_count++;
            end else begin
                w = pending_weights.pop_front();
                if (m_tdata[WT_W-1:0] !== w.wa)
                    report_mismatch("weight_a", m_tdata[WT_W-1:0], w.wa);
                if (m_tdata[2*WT_W-1:WT_W] !== w.wb)
                    report_mismatch("weight_b", m_tdata[2*WT_W-1:WT_W], w.wb);
                if (m_tdata[3*WT_W-1:2*WT_W] !== w.wc)
                    report_mismatch("weight_c", m_tdata[3*WT_W-1:2*WT_W], w.wc);
                if (m_tuser !== w.degen)
                    report_mismatch("degenerate", WT_W'(m_tuser), WT_W'(w.degen));
            end
        end
    end

    initial begin : sink
        int stall;
        forever begin
            @(negedge aclk);
            if (!no_idle && $urandom_range(0, 99) < 30) begin
                stall = pick_gap();
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
        end
    end

    initial begin : source
        int o[3], u1[3], e1[3], e2[3], mx[3], mn[3], tiny[3];
        int gap;
        request_t rq;
        o = '{0, 0, 0};
        u1 = '{1, 0, 0};
        e1 = '{32'h0001_0000, 0, 0};
        e2 = '{0, 32'h0001_0000, 0};
        mx = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
        mn = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        tiny = '{0, 1, 0};
        add_row(o, o, o, o, 1'b1, '0, '0, '0, 1'b1);
        add_row(mx, mx, mx, mx, 1'b1, '0, '0, '0, 1'b1);
        add_row(mn, mn, mn, mn, 1'b1, '0, '0, '0, 1'b1);
        add_row(o, o, e1, '{32'h0002_0000, 0, 0}, 1'b1, '0, '0, '0, 1'b1);
        add_row(mn, mn, mx, mx, 1'b1, '0, '0, '0, 1'b1);
        add_row(o, o, e1, e2, 1'b1, WT_ONE, '0, '0, 1'b0);
        add_row(e1, o, e1, e2, 1'b1, '0, WT_ONE, '0, 1'b0);
        add_row(e2, o, e1, e2, 1'b1, '0, '0, WT_ONE, 1'b0);
        add_row(mx, o, u1, tiny, 1'b1, WT_SAT, WT_SAT, WT_SAT, 1'b0);
        add_row(mn, o, u1, tiny, 1'b1, WT_SAT, WT_SAT, WT_SAT, 1'b0);
        add_row(mx, mn, '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000},
                '{32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000}, 1'b0, '0, '0, '0, 1'b0);
        add_row(mn, mx, '{32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff},
                '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff}, 1'b0, '0, '0, '0, 1'b0);
        add_row('{32'h0000_5555, 32'h0000_5555, 32'h0001_0000}, o, e1, e2,
                1'b0, '0, '0, '0, 1'b0);
        add_row('{32'hffff_0000, 32'hffff_0000, 0}, o, e1, e2, 1'b0, '0, '0, '0, 1'b0);
        add_row('{32'h5555_aaaa, 32'haaaa_5555, 32'hffff_ffff}, mn, mx,
                '{32'h0000_0001, 32'hffff_fffe, 32'h1234_5678}, 1'b0, '0, '0, '0, 1'b0);
        for (int n = 0; n < N_RANDOM; n++) add_random();

        repeat (5) @(negedge aclk);
        aresetn = 1'b1;
        for (int n = 0; n < requests.size(); n++) begin
            if (n % 200 == 0) no_idle = ($urandom_range(0, 3) == 0);
            rq = requests[n];
            gap = pick_gap();
            repeat (gap) @(negedge aclk);
            cur_req  = rq;
            s_tdata  = rq.data;
            s_tvalid = 1'b1;
            do @(posedge aclk); while (!s_tready);
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        no_idle = 1'b0;
        while (pending_weights.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (err_count == 0) begin
            $display("triangle_barycentric_weights_tb: done, clean");
        end else begin
            $display("triangle_barycentric_weights_tb: done, errors");
        end
        $finish;
    end
endmodule
